/* hdl/run_length_unpacker_unit_macros.svh */
// ----------------------------------------------------------------------------
// Run-length unpacker assertion macros
// Shorthand for the concurrent checks used in the run-length unpacker.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_UNPACKER_UNIT_MACROS_SVH
`define RUN_LENGTH_UNPACKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define RLU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
`define RLU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define RLU_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RLU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* hdl/rlu_pkg.sv */
// ----------------------------------------------------------------------------
// Run-length unpacker package
// Shared constants, phase codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rlu_pkg;

    localparam int ADDR_WIDTH = 16;

    localparam logic [7:0] RUN_FLAG = 8'h80;
    localparam logic [7:0] LEN_MASK = 8'h7f;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_REPEAT  = 2'd1;
    localparam logic [1:0] PH_LITERAL = 2'd2;

    typedef struct packed {
        logic        stream_end;
        logic [6:0]  repeat_count;
        logic [7:0]  write_value;
        logic [15:0] write_address;
    } rlu_result_t;

endpackage

`default_nettype wire

/* hdl/rlu_decoder.sv */
// ----------------------------------------------------------------------------
// Run-length unpacker decoder
// Holds the stream phase, literal count, repeat count and write address, and turns each
// byte into at most one write command.
// ----------------------------------------------------------------------------
`default_nettype none

module rlu_decoder
    import rlu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  wire logic [7:0]  packed_byte,
    output logic             res_valid,
    output rlu_result_t      res
);

    logic [1:0]            phase_reg, phase_next;
    logic [6:0]            bytes_left_reg, bytes_left_next;
    logic [6:0]            run_count_reg, run_count_next;
    logic [ADDR_WIDTH-1:0] next_address_reg, next_address_next;
    logic [31:0]           addr_wide;

    assign addr_wide = 32'(next_address_reg);

    always_comb begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        run_count_next    = run_count_reg;
        next_address_next = next_address_reg;
        res_valid         = 1'b0;
        res.write_address = addr_wide[15:0];
        res.write_value   = packed_byte;
        res.repeat_count  = 7'd1;
        res.stream_end    = 1'b0;
        unique case (phase_reg)
            PH_REPEAT: begin
                phase_next       = PH_HEADER;
                res.repeat_count = run_count_reg;
                if (run_count_reg != 7'd0) begin
                    res_valid         = 1'b1;
                    next_address_next = next_address_reg + ADDR_WIDTH'(run_count_reg);
                end
            end
            PH_LITERAL: begin
                res_valid         = 1'b1;
                next_address_next = next_address_reg + ADDR_WIDTH'(1);
                bytes_left_next   = bytes_left_reg - 7'd1;
                if (bytes_left_next == 7'd0) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                if (packed_byte == 8'd0) begin
                    res_valid         = 1'b1;
                    res.write_value   = 8'd0;
                    res.repeat_count  = 7'd0;
                    res.stream_end    = 1'b1;
                    next_address_next = '0;
                    bytes_left_next   = 7'd0;
                    phase_next        = PH_HEADER;
                end else if ((packed_byte & RUN_FLAG) != 8'd0) begin
                    run_count_next = 7'(packed_byte & LEN_MASK);
                    phase_next     = PH_REPEAT;
                end else begin
                    bytes_left_next = 7'(packed_byte & LEN_MASK);
                    phase_next      = PH_LITERAL;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            bytes_left_reg   <= 7'd0;
            run_count_reg    <= 7'd0;
            next_address_reg <= '0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            run_count_reg    <= run_count_next;
            next_address_reg <= next_address_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/rlu_out_reg.sv */
// ----------------------------------------------------------------------------
// Run-length unpacker output register
// Holds one write command until the receiver takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rlu_out_reg
    import rlu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         load,
    input  wire rlu_result_t  load_data,
    input  wire logic         out_ready,
    output logic              out_valid,
    output rlu_result_t       out_data
);

    logic        valid_reg, valid_next;
    rlu_result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* hdl/run_length_unpacker_unit.sv */
// ----------------------------------------------------------------------------
// Run-length unpacker
// Expands a packed byte stream into write commands (address, value, count).
// ----------------------------------------------------------------------------
// The s_ channel takes one stream byte per beat: a header, a repeat value or
// a literal. The m_ channel gives one write command per beat, with the start
// address, the byte value and the repeat count in m_tdata. A zero header
// gives a beat with m_tlast high, count and value zero, and the address just
// past the last write; the address then restarts at zero.
// A byte is registered at the input, decoded from the input register and its
// command is registered at the output when the byte advances. One byte is
// taken per cycle while the output register is empty or its beat is taken;
// non-zero headers and zero-length repeats give no output beat. The rate
// is set by the single decode stage between the input and output registers.
// When the receiver holds m_tready low, the output register keeps its beat
// and the input register fills; s_tready then drops until the beat is taken.
// Reset clears the phase to expecting a header, the address to zero and both
// registers to empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "run_length_unpacker_unit_macros.svh"

module run_length_unpacker_unit
    import rlu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // packed_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // write_address, write_value, repeat_count, zero
    output logic             m_tlast
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        res_valid;
    rlu_result_t res;
    rlu_result_t out_data;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    rlu_decoder u_decoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .packed_byte (in_byte_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    rlu_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && res_valid),
        .load_data (res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data)
    );

    assign m_tdata = {1'b0, out_data.repeat_count, out_data.write_value,
                      out_data.write_address};
    assign m_tlast = out_data.stream_end;

    `RLU_ASSERT_IMPL(a_end_beat_empty, aclk, aresetn, m_tvalid && m_tlast,
                     m_tdata[30:16] == 15'd0)
    `RLU_ASSERT_IMPL(a_write_nonzero, aclk, aresetn, m_tvalid && !m_tlast,
                     m_tdata[30:24] != 7'd0)
    `RLU_ASSERT_IMPL(a_ready_when_drained, aclk, aresetn, !m_tvalid, s_tready)
    `RLU_ASSERT_NEXT(a_stall_keeps_input, aclk, aresetn,
                     in_valid_reg && m_tvalid && !m_tready, in_valid_reg)

endmodule

`default_nettype wire

/* test/run_length_unpacker_checker.sv */
// ----------------------------------------------------------------------------
// Run-length unpacker checker
// Watches both channels of the run-length unpacker. It decodes every accepted
// input beat into the write command that it should cause, keeps these
// commands in order, and compares each output beat field by field with the
// oldest one. It reports the number of mismatches and the number of commands
// still outstanding.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_unpacker_checker
    import rlu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // packed_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // write_address, write_value, repeat_count, zero
    input  wire logic        m_tlast,
    output int unsigned      mismatch_count,
    output int unsigned      pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]            decode_phase = PH_HEADER;
    logic [6:0]            literals_left = '0;
    logic [6:0]            run_length = '0;
    logic [ADDR_WIDTH-1:0] next_write_addr = '0;
    rlu_result_t           pending_writes[$];

    function automatic void decode_packed_byte(input logic [7:0] pbyte);
        rlu_result_t cmd;
        cmd = '0;
        cmd.write_address = 16'(next_write_addr);
        cmd.write_value   = pbyte;
        case (decode_phase)
            PH_REPEAT: begin
                decode_phase = PH_HEADER;
                if (run_length != '0) begin
                    cmd.repeat_count = run_length;
                    pending_writes.push_back(cmd);
                    next_write_addr = next_write_addr + run_length;
                end
            end
            PH_LITERAL: begin
                cmd.repeat_count = 7'd1;
                pending_writes.push_back(cmd);
                next_write_addr = next_write_addr + 1'b1;
                literals_left = literals_left - 1'b1;
                if (literals_left == '0) begin
                    decode_phase = PH_HEADER;
                end
            end
            default: begin
                if (pbyte == 8'h00) begin
                    cmd.write_value = 8'h00;
                    cmd.stream_end  = 1'b1;
                    pending_writes.push_back(cmd);
                    next_write_addr = '0;
                    literals_left = '0;
                    decode_phase = PH_HEADER;
                end else if ((pbyte & RUN_FLAG) != 8'h00) begin
                    run_length = 7'(pbyte & LEN_MASK);
                    decode_phase = PH_REPEAT;
                end else begin
                    literals_left = 7'(pbyte & LEN_MASK);
                    decode_phase = PH_LITERAL;
                end
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        rlu_result_t exp_cmd;
        if (!aresetn) begin
            decode_phase = PH_HEADER;
            literals_left = '0;
            run_length = '0;
            next_write_addr = '0;
            pending_writes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t: unexpected write beat, expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    exp_cmd = pending_writes.pop_front();
                    if (m_tdata[15:0] !== exp_cmd.write_address ||
                        m_tdata[23:16] !== exp_cmd.write_value ||
                        m_tdata[30:24] !== exp_cmd.repeat_count ||
                        m_tlast !== exp_cmd.stream_end) begin
                        $display("%0t: write beat mismatch, expected addr %h value %h count %0d end %b",
                                 $time, exp_cmd.write_address, exp_cmd.write_value,
                                 exp_cmd.repeat_count, exp_cmd.stream_end);
                        $display("%0t:                      actual addr %h value %h count %0d end %b",
                                 $time, m_tdata[15:0], m_tdata[23:16], m_tdata[30:24], m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_packed_byte(s_tdata);
            end
        end
        pending_count = pending_writes.size();
    end

endmodule

`default_nettype wire

/* test/tb_run_length_unpacker_unit.sv */
// ----------------------------------------------------------------------------
// Run-length unpacker testbench
// Feeds the unpacker with packed byte streams: a short directed sequence,
// then random well-formed streams mixed with stray bytes, and one long stream
// of maximum repeats that wraps the write address. Both channels idle at
// random, and the receiver once holds off long enough to back up the input.
// A separate checker predicts and compares every write beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_run_length_unpacker_unit
    import rlu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_START     = 400;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WRAP_REPEATS   = 540;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int          send_gap_pct = 0;
    int          accept_gap_pct = 0;
    int          bytes_sent = 0;
    int          run_cycles = 0;
    int          quiet_cycles = 0;

    run_length_unpacker_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    run_length_unpacker_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        run_cycles <= run_cycles + 1;
        if (run_cycles >= HOLD_START && run_cycles < HOLD_START + HOLD_CYCLES) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= accept_gap_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] pbyte);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pbyte;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    task automatic send_repeat(input logic [6:0] count, input logic [7:0] value);
        send_byte(RUN_FLAG | {1'b0, count});
        send_byte(value);
    endtask

    task automatic send_literals(input logic [6:0] count);
        send_byte({1'b0, count});
        repeat (count) send_byte(8'($urandom));
    endtask

    task automatic send_stream(input int n_cmds, input bit terminate);
        int pick;
        int n;
        for (int i = 0; i < n_cmds; i++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(15);
                send_repeat(7'(n), 8'($urandom));
            end else if (pick < 92) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(127, 1) : $urandom_range(8, 1);
                send_literals(7'(n));
            end else begin
                send_byte(8'($urandom));
            end
        end
        if (terminate) begin
            send_byte(8'h00);
        end
    endtask

    task automatic send_until(input int byte_quota);
        while (bytes_sent < byte_quota) begin
            send_stream($urandom_range(8, 1), $urandom_range(99) < 85);
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_gap_pct = 36;
        accept_gap_pct = 66;

        send_byte(8'h00);
        send_repeat(7'd127, 8'h00);
        send_repeat(7'd0, 8'hab);
        send_repeat(7'd1, 8'hff);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'hff);
        send_byte(8'h55);
        send_byte(8'haa);
        send_byte(8'h00);
        send_byte(8'h00);

        send_until(380);

        send_gap_pct = 66;
        accept_gap_pct = 36;
        send_until(760);

        send_gap_pct = 0;
        accept_gap_pct = 0;
        // All bytes of the wrap stream are equal, so it lines up with the
        // headers whatever phase the random part left the block in.
        repeat (WRAP_REPEATS) send_repeat(7'd127, 8'hff);
        send_byte(8'h00);
        send_until(1850);
        s_tvalid <= 1'b0;

        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
